>>> rtl/ipv4_header_forwarder_macros.svh
// Assertion macros for the IPv4 header forwarder.
// Included by the top level; no other dependencies.
`ifndef IPV4_HEADER_FORWARDER_MACROS_SVH
`define IPV4_HEADER_FORWARDER_MACROS_SVH

// implication checked on every clock edge out of reset
`define IHF_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// implication checked on the next clock edge
`define IHF_ASSERT_NXT(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

>>> rtl/ihf_pkg.sv
// Shared types and constants for the IPv4 header forwarder.
// No dependencies.
`default_nettype none
package ihf_pkg;
    localparam int HDR_DEPTH = 15;
    localparam int CNT_W     = 4;

    typedef enum logic [1:0] {
        V_LOCAL   = 2'd0,
        V_FORWARD = 2'd1,
        V_TTL     = 2'd2,
        V_NOROUTE = 2'd3
    } t_verdict;

    // controller -> datapath
    typedef struct packed {
        logic add_start;   // latch route add, begin table scan
        logic hdr_store;   // store header word
        logic hdr_clear;   // clear word count
        logic lk_start;    // begin lookup and checksum scan
        logic scan_step;   // advance scan index
        logic out_load;    // load checksum register, or commit the route add
        logic out_next;    // advance output index
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;   // last table entry / header word visited
        logic early;       // verdict decided without forwarding
        logic out_last;    // current output is the final one
    } t_stat;

    function automatic logic [31:0] pfx_mask(input logic [5:0] len);
        logic [5:0] l;
        l = (len > 6'd32) ? 6'd32 : len;
        if (l == 6'd0) return 32'h0;
        return 32'hFFFF_FFFF << (6'd32 - l);
    endfunction
endpackage
`default_nettype wire

>>> rtl/ihf_datapath.sv
// Datapath: route table, header buffer, lookup/checksum scan, output register.
// Depends on ihf_pkg.
`default_nettype none
module ihf_datapath #(
    parameter int ROUTES = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire ihf_pkg::t_cmd  i_cmd,
    output ihf_pkg::t_stat      o_stat,
    input  wire logic [31:0]    i_local,
    input  wire logic [31:0]    i_word,
    input  wire logic [5:0]     i_plen,
    input  wire logic [31:0]    i_hop,
    output logic [1:0]          o_verdict,
    output logic [31:0]         o_next_hop,
    output logic [31:0]         o_out_word,
    output logic                o_end
);
    import ihf_pkg::*;
    localparam int RW = (ROUTES > 1) ? $clog2(ROUTES) : 1;
    localparam int SW = ((RW > CNT_W) ? RW : CNT_W) + 1;

    logic [31:0] r_pfx [ROUTES];
    logic [5:0]  r_len [ROUTES];
    logic [31:0] r_rhop [ROUTES];
    logic [ROUTES-1:0] r_valid;
    logic [31:0] r_hdr [HDR_DEPTH];
    logic [CNT_W-1:0] r_cnt;

    logic        r_is_add;
    logic [31:0] r_apfx;
    logic [5:0]  r_alen;
    logic [31:0] r_ahop;
    logic        r_dup;
    logic        r_free_ok;
    logic [RW-1:0] r_free;

    logic [SW-1:0] r_idx;
    logic [31:0] r_dst;
    logic        r_found;
    logic [5:0]  r_best;
    logic [31:0] r_bhop;
    logic [31:0] r_w2;
    logic [3:0]  r_ihl;
    logic [20:0] r_sum;
    logic [CNT_W-1:0] r_oidx;
    logic [15:0] r_ck;

    logic [RW-1:0] ridx;
    logic [CNT_W-1:0] hidx;
    logic [31:0] hw0, hw2, hw4, hsel;
    logic [7:0]  ttl;
    logic        match;
    logic [16:0] f1;
    logic [15:0] fold;

    assign ridx = r_idx[RW-1:0];
    assign hidx = r_idx[CNT_W-1:0];
    assign hw0 = (r_cnt > 4'd0) ? r_hdr[0] : 32'h0;
    assign hw2 = (r_cnt > 4'd2) ? r_hdr[2] : 32'h0;
    assign hw4 = (r_cnt > 4'd4) ? r_hdr[4] : 32'h0;
    assign ttl = hw2[31:24];
    assign hsel = (hidx == 4'd2) ? r_w2 :
                  ((hidx < r_cnt && hidx < 4'(HDR_DEPTH)) ? r_hdr[hidx] : 32'h0);
    assign match = r_valid[ridx] && ((r_dst & pfx_mask(r_len[ridx])) == r_pfx[ridx]);
    assign f1 = {1'b0, r_sum[15:0]} + {12'h0, r_sum[20:16]};
    assign fold = f1[15:0] + {15'h0, f1[16]};

    always_comb begin
        o_stat.early     = (hw4 == i_local) || (ttl == 8'd0) || !r_found;
        o_stat.scan_done = r_is_add ? (ridx == RW'(ROUTES - 1))
                                    : ((r_idx >= SW'(ROUTES - 1)) &&
                                       (r_idx >= SW'(HDR_DEPTH)));
        o_stat.out_last  = (r_oidx + 4'd1 >= r_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_cnt   <= '0;
            for (int k = 0; k < ROUTES; k++) begin
                r_pfx[k] <= '0; r_len[k] <= '0; r_rhop[k] <= '0;
            end
        end else begin
            if (i_cmd.add_start) begin
                r_is_add  <= 1'b1;
                r_apfx    <= i_word & pfx_mask(i_plen);
                r_alen    <= (i_plen > 6'd32) ? 6'd32 : i_plen;
                r_ahop    <= i_hop;
                r_dup     <= 1'b0;
                r_free_ok <= 1'b0;
                r_idx     <= '0;
            end
            if (i_cmd.hdr_store && r_cnt < 4'(HDR_DEPTH)) begin
                r_hdr[r_cnt] <= i_word;
                r_cnt <= r_cnt + 4'd1;
            end
            if (i_cmd.lk_start) begin
                r_is_add <= 1'b0;
                r_idx    <= '0;
                r_dst    <= hw4;
                r_found  <= 1'b0;
                r_best   <= '0;
                r_bhop   <= '0;
                r_w2     <= {ttl - 8'd1, hw2[23:16], 16'h0};
                r_ihl    <= hw0[27:24];
                r_sum    <= '0;
                r_oidx   <= '0;
            end
            if (i_cmd.scan_step) begin
                r_idx <= r_idx + SW'(1);
                if (r_is_add) begin
                    if (r_valid[ridx] && r_pfx[ridx] == r_apfx && r_len[ridx] == r_alen)
                        r_dup <= 1'b1;
                    if (!r_valid[ridx] && !r_free_ok) begin
                        r_free_ok <= 1'b1;
                        r_free    <= ridx;
                    end
                end else begin
                    if (r_idx < SW'(ROUTES) && match && (!r_found || r_len[ridx] > r_best)) begin
                        r_found <= 1'b1;
                        r_best  <= r_len[ridx];
                        r_bhop  <= r_rhop[ridx];
                    end
                    if (r_idx < SW'(HDR_DEPTH) && hidx < r_ihl)
                        r_sum <= r_sum + 21'(hsel[31:16]) + 21'(hsel[15:0]);
                end
            end
            if (i_cmd.out_load && r_is_add) begin
                if (!r_dup && r_free_ok) begin
                    r_pfx[r_free]  <= r_apfx;
                    r_len[r_free]  <= r_alen;
                    r_rhop[r_free] <= r_ahop;
                    r_valid[r_free] <= 1'b1;
                end
            end
            if (i_cmd.out_load && !r_is_add) r_ck <= ~fold;
            if (i_cmd.out_next) r_oidx <= r_oidx + 4'd1;
            if (i_cmd.hdr_clear) r_cnt <= '0;
        end
    end

    // output select: verdict, next hop, output word and end flag
    always_comb begin
        o_verdict  = V_FORWARD;
        o_next_hop = r_bhop;
        o_out_word = (r_oidx == 4'd2) ? (r_w2 | {16'h0, r_ck}) : r_hdr[r_oidx];
        o_end      = o_stat.out_last;
        if (hw4 == i_local) begin
            o_verdict = V_LOCAL;
        end else if (ttl == 8'd0) begin
            o_verdict = V_TTL;
        end else if (!r_found) begin
            o_verdict = V_NOROUTE;
        end
        if (o_verdict != V_FORWARD) begin
            o_next_hop = '0; o_out_word = '0; o_end = 1'b1;
        end
    end
endmodule
`default_nettype wire

>>> rtl/ihf_ctrl.sv
// Controller state machine for the IPv4 header forwarder.
// Depends on ihf_pkg.
`default_nettype none
module ihf_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_op,
    input  wire logic           i_last,
    output logic                o_in_ready,
    input  wire logic           i_out_ready,
    output logic                o_out_valid,
    input  wire ihf_pkg::t_stat i_stat,
    output ihf_pkg::t_cmd       o_cmd
);
    import ihf_pkg::*;
    typedef enum logic [2:0] {S_IDLE, S_ADD, S_ADDW, S_SCAN, S_FIN, S_OUT} t_state;
    t_state r_state;
    logic acc;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign acc = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd = '0;
        o_cmd.add_start = acc && !i_op;
        o_cmd.hdr_store = acc && i_op;
        o_cmd.lk_start  = (r_state == S_FIN);
        o_cmd.scan_step = (r_state == S_ADD) || (r_state == S_SCAN);
        o_cmd.out_load  = (r_state == S_ADDW) || (r_state == S_SCAN && i_stat.scan_done);
        o_cmd.out_next  = (r_state == S_OUT) && i_out_ready;
        o_cmd.hdr_clear = (r_state == S_OUT) && i_out_ready
                          && (i_stat.out_last || i_stat.early);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (acc && !i_op) r_state <= S_ADD;
                    else if (acc && i_last) r_state <= S_FIN;
                end
                S_ADD:  if (i_stat.scan_done) r_state <= S_ADDW;
                S_ADDW: r_state <= S_IDLE;
                S_FIN:  r_state <= S_SCAN;
                S_SCAN: if (i_stat.scan_done) r_state <= S_OUT;
                S_OUT: begin
                    if (o_cmd.hdr_clear) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> rtl/ipv4_header_forwarder.sv
// Top level of the IPv4 header forwarder: controller plus datapath.
// Depends on ihf_pkg, ihf_ctrl, ihf_datapath and the assertion macros.
//
// channel  dir  tdata                             tuser    tlast
// s_axis   in   {route_next_hop,prefix_len,word}  op       last
// m_axis   out  {out_word,next_hop}               verdict  end_of_run
// cfg      in   local_address
//
// Route add: input ready again after the serial table scan (S_ADD) and the
// table write (S_ADDW). Header words are taken back to back; after the last
// word, the lookup/checksum scan runs, then one result per cycle held until taken.
// Reset synchronous, active low; input is stalled while a scan or results are pending.
`default_nettype none
`include "ipv4_header_forwarder_macros.svh"
module ipv4_header_forwarder #(
    parameter int ROUTES = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [31:0] word, [37:32] prefix_len, [69:38] route_next_hop
    input  wire logic [71:0]  s_axis_tdata,
    // [0] op
    input  wire logic         s_axis_tuser,
    input  wire logic         s_axis_tlast,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [31:0] next_hop, [63:32] out_word
    output logic [63:0]       m_axis_tdata,
    // [1:0] verdict
    output logic [1:0]        m_axis_tuser,
    output logic              m_axis_tlast,
    input  wire logic         i_cfg_we,
    input  wire logic [31:0]  i_cfg_wdata
);
    import ihf_pkg::*;
    t_cmd  cmd;
    t_stat stat;
    logic [31:0] r_local;
    logic [1:0]  verdict;
    logic [31:0] nh, ow;
    logic        eor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_local <= '0;
        else if (i_cfg_we) r_local <= i_cfg_wdata;
    end

    ihf_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(s_axis_tvalid), .i_op(s_axis_tuser), .i_last(s_axis_tlast),
        .o_in_ready(s_axis_tready), .i_out_ready(m_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_stat(stat), .o_cmd(cmd)
    );

    ihf_datapath #(.ROUTES(ROUTES)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_stat(stat), .i_local(r_local),
        .i_word(s_axis_tdata[31:0]), .i_plen(s_axis_tdata[37:32]),
        .i_hop(s_axis_tdata[69:38]),
        .o_verdict(verdict), .o_next_hop(nh), .o_out_word(ow), .o_end(eor)
    );

    assign m_axis_tdata = {ow, nh};
    assign m_axis_tuser = verdict;
    assign m_axis_tlast = eor;

    `IHF_ASSERT_IMP(a_no_overlap, s_axis_tready, !m_axis_tvalid)
    `IHF_ASSERT_NXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable({m_axis_tuser, m_axis_tlast, m_axis_tdata}))
    `IHF_ASSERT_IMP(a_drop_end, m_axis_tvalid && (verdict != V_FORWARD), eor)
endmodule
`default_nettype wire

>>> tb/tb_ipv4_header_forwarder.sv
// Testbench for ipv4_header_forwarder: route adds, header judging and forwarding.
// Depends on ihf_pkg and the RTL; predicts results internally and checks each one.
`timescale 1ns / 1ps
`default_nettype none
module tb_ipv4_header_forwarder;
    import ihf_pkg::*;

    localparam int NROUTES = 16;
    localparam bit OP_ADD = 1'b0;
    localparam bit OP_HDR = 1'b1;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        t_verdict    verdict;
        logic [31:0] next_hop;
        logic [31:0] out_word;
        logic        end_of_run;
    } t_result;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // [31:0] word, [37:32] prefix_len, [69:38] route_next_hop
    logic [71:0]  s_axis_tdata;
    // [0] op
    logic         s_axis_tuser;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // [31:0] next_hop, [63:32] out_word
    logic [63:0]  m_axis_tdata;
    // [1:0] verdict
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;
    logic         i_cfg_we;
    logic [31:0]  i_cfg_wdata;

    ipv4_header_forwarder #(.ROUTES(NROUTES)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    // predictor state
    logic [31:0] my_addr;
    logic [31:0] tbl_prefix [NROUTES];
    logic [5:0]  tbl_len    [NROUTES];
    logic [31:0] tbl_hop    [NROUTES];
    logic        tbl_valid  [NROUTES];
    logic [31:0] hdr_buf    [HDR_DEPTH];
    int          hdr_cnt;

    t_result     pending_results[$];
    int          mismatches;
    int          results_seen;
    int          items_sent;
    int          packets_sent;
    int          cycles;
    bit          hold_off;
    bit          burst_rx;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic [31:0] route_mask(input logic [5:0] len);
        if (len == 6'd0) return 32'h0;
        if (len > 6'd32) return 32'hFFFF_FFFF;
        return 32'hFFFF_FFFF << (6'd32 - len);
    endfunction

    function automatic logic [31:0] buf_word(input int i);
        return (i < hdr_cnt) ? hdr_buf[i] : 32'h0;
    endfunction

    task automatic learn_route(input logic [31:0] dest, input logic [5:0] len_in,
                               input logic [31:0] hop);
        logic [5:0]  len;
        logic [31:0] pre;
        int          slot;
        slot = -1;
        len = (len_in > 6'd32) ? 6'd32 : len_in;
        pre = dest & route_mask(len);
        for (int i = 0; i < NROUTES; i++) begin
            if (tbl_valid[i]) begin
                if (tbl_prefix[i] == pre && tbl_len[i] == len) return;
            end else if (slot < 0) begin
                slot = i;
            end
        end
        if (slot < 0) return;
        tbl_prefix[slot] = pre;
        tbl_len[slot] = len;
        tbl_hop[slot] = hop;
        tbl_valid[slot] = 1'b1;
    endtask

    task automatic judge_packet();
        logic [3:0]  ihl;
        logic [7:0]  ttl;
        logic [31:0] dst, hop, w2, w, sum, hw0, hw2;
        logic [5:0]  best;
        bit          found;
        t_result     r;
        hw0 = buf_word(0);
        hw2 = buf_word(2);
        ihl = hw0[27:24];
        ttl = hw2[31:24];
        dst = buf_word(4);
        found = 0;
        best = 0;
        hop = 0;
        r = '0;
        r.end_of_run = 1'b1;
        if (dst == my_addr) begin
            r.verdict = V_LOCAL;
            pending_results.push_back(r);
            return;
        end
        if (ttl == 8'd0) begin
            r.verdict = V_TTL;
            pending_results.push_back(r);
            return;
        end
        for (int i = 0; i < NROUTES; i++) begin
            if (tbl_valid[i] && (dst & route_mask(tbl_len[i])) == tbl_prefix[i]
                && (!found || tbl_len[i] > best)) begin
                found = 1;
                best = tbl_len[i];
                hop = tbl_hop[i];
            end
        end
        if (!found) begin
            r.verdict = V_NOROUTE;
            pending_results.push_back(r);
            return;
        end
        w2 = {ttl - 8'd1, hw2[23:16], 16'h0};
        sum = 0;
        for (int i = 0; i < ihl; i++) begin
            w = (i == 2) ? w2 : buf_word(i);
            sum += w[31:16] + w[15:0];
        end
        while (sum[31:16] != 0) sum = sum[15:0] + sum[31:16];
        w2[15:0] = ~sum[15:0];
        for (int i = 0; i < hdr_cnt; i++) begin
            r.verdict = V_FORWARD;
            r.next_hop = hop;
            r.out_word = (i == 2) ? w2 : hdr_buf[i];
            r.end_of_run = (i + 1 == hdr_cnt);
            pending_results.push_back(r);
        end
    endtask

    task automatic send_item(input bit op, input logic [31:0] word, input bit last,
                             input logic [5:0] plen, input logic [31:0] nhop);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, nhop, plen, word};
        s_axis_tuser <= op;
        s_axis_tlast <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
        if (op == OP_ADD) begin
            learn_route(word, plen, nhop);
        end else begin
            if (hdr_cnt < HDR_DEPTH) hdr_buf[hdr_cnt++] = word;
            if (last) begin
                judge_packet();
                hdr_cnt = 0;
                packets_sent++;
            end
        end
    endtask

    task automatic idle_gap();
        int n;
        if ($urandom_range(0, 3) != 0) return;
        n = $urandom_range(1, 6);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_local(input logic [31:0] a);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= a;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        my_addr = a;
    endtask

    // header of random words; ihl, ttl and dst chosen by caller
    task automatic send_header(input int nwords, input logic [3:0] ihl,
                               input logic [7:0] ttl, input logic [31:0] dst);
        logic [31:0] w;
        for (int i = 0; i < nwords; i++) begin
            w = {$urandom};
            if (i == 0) w[27:24] = ihl;
            if (i == 2) w[31:24] = ttl;
            if (i == 4) w = dst;
            send_item(OP_HDR, w, i == nwords - 1, 6'($urandom), {$urandom});
            idle_gap();
        end
    endtask

    function automatic logic [31:0] pick_dst();
        int k;
        k = $urandom_range(0, NROUTES - 1);
        case ($urandom_range(0, 3))
            0: return {$urandom};
            1: return my_addr;
            default: return tbl_valid[k] ? (tbl_prefix[k] | ($urandom & ~route_mask(tbl_len[k])))
                                         : {$urandom};
        endcase
    endfunction

    task automatic test_directed();
        write_local(32'h0A00_0001);
        send_header(5, 4'd5, 8'd64, 32'h0808_0808);      // no route
        send_item(OP_ADD, 32'hC0A8_0000, 1'b0, 6'd16, 32'h1111_1111);
        send_item(OP_ADD, 32'hC0A8_0100, 1'b0, 6'd24, 32'h2222_2222);
        send_item(OP_ADD, 32'hC0A8_01FF, 1'b0, 6'd24, 32'h3333_3333); // duplicate
        send_item(OP_ADD, 32'hFFFF_FFFF, 1'b0, 6'd63, 32'hFFFF_FFFF); // too long
        send_item(OP_ADD, 32'h0000_0000, 1'b0, 6'd0, 32'h4444_4444);  // default
        send_header(5, 4'd5, 8'd64, 32'hC0A8_0105);      // longest match
        send_header(5, 4'd5, 8'd0, 32'hC0A8_0105);       // ttl zero
        send_header(5, 4'd5, 8'd1, 32'h0A00_0001);       // local
        send_header(5, 4'd15, 8'd255, 32'hFFFF_FFFF);    // full mask, ihl max
        send_header(2, 4'd5, 8'd9, 32'h0);               // short header
        send_header(18, 4'd0, 8'd2, 32'h0102_0304);      // long header, ihl zero
        send_item(OP_HDR, 32'hFFFF_FFFF, 1'b0, 6'd0, 32'h0);
        send_item(OP_ADD, 32'h0A0B_0C0D, 1'b0, 6'd32, 32'h5555_5555); // add mid-header
        send_item(OP_HDR, 32'h0, 1'b1, 6'd0, 32'h0);
        drain();
    endtask

    task automatic test_random();
        for (int p = 0; p < 15; p++) begin
            if ($urandom_range(0, 4) == 0) begin
                send_item(OP_ADD, $urandom, 1'($urandom), 6'($urandom_range(0, 63)), $urandom);
                idle_gap();
            end
            if ($urandom_range(0, 9) == 0)
                send_header($urandom_range(1, 17), 4'($urandom), 8'($urandom), {$urandom});
            else
                send_header($urandom_range(5, 7), 4'd5, $urandom_range(0, 3) == 0 ? 8'd0 :
                            8'($urandom), pick_dst());
        end
        drain();
    endtask

    task automatic test_table_full();
        for (int i = 0; i < 20; i++)
            send_item(OP_ADD, $urandom, 1'b0, 6'($urandom_range(8, 32)), $urandom);
        drain();
        write_local(32'hFFFF_FFFF);
        for (int p = 0; p < 10; p++)
            send_header($urandom_range(5, 15), 4'($urandom_range(5, 15)), 8'($urandom),
                        pick_dst());
        drain();
        write_local(32'h0000_0000);
    endtask

    task automatic test_backpressure();
        hold_off = 1;
        for (int p = 0; p < 6; p++)
            send_header(15, 4'd15, 8'd77, pick_dst());
        hold_off = 0;
        drain();
        // sender pauses until everything is out
        send_header(6, 4'd6, 8'd3, pick_dst());
        drain();
    endtask

    // receiver stall pattern, with a long hold-off counted in cycles
    initial begin
        int hold;
        m_axis_tready = 1'b0;
        burst_rx = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                hold = 300;
                m_axis_tready <= 1'b0;
                while (hold > 0) begin
                    @(negedge i_clk);
                    hold--;
                end
            end
            if ($urandom_range(0, 63) == 0) burst_rx = ~burst_rx;
            m_axis_tready <= burst_rx ? 1'b1 : ($urandom_range(0, 2) != 0);
        end
    end

    task automatic report(input string what, input logic [66:0] want, input logic [66:0] got);
        mismatches++;
        if (mismatches < 50)
            $display("mismatch %s: want %h got %h at cycle %0d", what, want, got, cycles);
    endtask

    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.verdict    = t_verdict'(m_axis_tuser);
            got.next_hop   = m_axis_tdata[31:0];
            got.out_word   = m_axis_tdata[63:32];
            got.end_of_run = m_axis_tlast;
            results_seen++;
            if (pending_results.size() == 0) begin
                report("result with none expected", 0, got);
            end else begin
                want = pending_results.pop_front();
                if (got.verdict != want.verdict) report("verdict", want.verdict, got.verdict);
                if (got.next_hop != want.next_hop) report("next_hop", want.next_hop, got.next_hop);
                if (got.out_word != want.out_word) report("out_word", want.out_word, got.out_word);
                if (got.end_of_run != want.end_of_run)
                    report("end_of_run", want.end_of_run, got.end_of_run);
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        s_axis_tlast = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        packets_sent = 0;
        cycles = 0;
        hold_off = 0;
        my_addr = 0;
        hdr_cnt = 0;
        for (int i = 0; i < NROUTES; i++) begin
            tbl_prefix[i] = 0;
            tbl_len[i] = 0;
            tbl_hop[i] = 0;
            tbl_valid[i] = 0;
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (40) @(posedge i_clk);
        test_directed();
        test_random();
        test_backpressure();
        test_table_full();
        test_random();
        if (pending_results.size() != 0) report("results left over", 0, pending_results.size());
        $display("covered %0d items, %0d packets, %0d results checked",
                 items_sent, packets_sent, results_seen);
        $display("routes: duplicates, full table, default and host routes; all verdicts");
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire

>>> sim.f
+incdir+rtl
rtl/ihf_pkg.sv
rtl/ihf_datapath.sv
rtl/ihf_ctrl.sv
rtl/ipv4_header_forwarder.sv
tb/tb_ipv4_header_forwarder.sv
